[design/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// LBP package
// Shared types, widths, register indexes and helpers for the 3x3 local
// binary pattern pixel stream block.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_W   = 13;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WIDTH_CFG_W = 11;

  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_MAX   = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int BORDER_PX    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                 emit;
    logic                 frame_end;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
  } pos_flags_t;

  function automatic logic [31:0] clamp_u(input logic [31:0] v,
                                          input logic [31:0] lo,
                                          input logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

[design/lbp_line_buf.sv]
// ----------------------------------------------------------------------------
// LBP line buffer
// Two image rows packed into one memory word per column, with a registered
// read and a bypass for a write and read of the same column in one cycle.
// ----------------------------------------------------------------------------
module lbp_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
  input  logic [lbp_pkg::LINE_W-1:0]          wr_data,
  output logic [lbp_pkg::LINE_W-1:0]          rd_data
);

  logic [lbp_pkg::LINE_W-1:0] mem [MAX_WIDTH];
  logic [lbp_pkg::LINE_W-1:0] rd_q;
  logic [lbp_pkg::LINE_W-1:0] fwd_data;
  logic                       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

[design/lbp_pos_ctrl.sv]
// ----------------------------------------------------------------------------
// LBP position control
// Holds the image size registers and the row and column counters, and
// works out the column address and output flags of each accepted pixel.
// ----------------------------------------------------------------------------
module lbp_pos_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                advance,
  input  logic                                frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0]        col,
  output lbp_pkg::pos_flags_t                 flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [WW-1:0]                eff_w;
  logic [lbp_pkg::HEIGHT_W-1:0] eff_h;
  logic [CW-1:0]                col_count;
  logic [lbp_pkg::ROW_W-1:0]    row_count;

  logic [CW-1:0]                col_next;
  logic [lbp_pkg::ROW_W-1:0]    row_next;
  logic [CW-1:0]                c0;
  logic [CW-1:0]                c1;
  logic [lbp_pkg::ROW_W-1:0]    r0;
  logic [lbp_pkg::ROW_W-1:0]    r1;
  logic [lbp_pkg::HEIGHT_W-1:0] r1x;
  logic                         wrap0;
  logic                         last_col;
  logic                         last_row;

  always_comb begin
    c0    = frame_start ? '0 : col_count;
    r0    = frame_start ? '0 : row_count;
    wrap0 = {1'b0, c0} >= eff_w;
    c1    = wrap0 ? '0 : c0;
    r1x   = wrap0 ? ({1'b0, r0} + lbp_pkg::HEIGHT_W'(1)) : {1'b0, r0};
    r1    = (r1x >= eff_h) ? '0 : r1x[lbp_pkg::ROW_W-1:0];

    last_col = {1'b0, c1} == (eff_w - WW'(1));
    last_row = {1'b0, r1} == (eff_h - lbp_pkg::HEIGHT_W'(1));

    flags.emit      = (r1 >= lbp_pkg::ROW_W'(lbp_pkg::BORDER_PX)) &&
                      (c1 >= CW'(lbp_pkg::BORDER_PX));
    flags.frame_end = last_row && last_col;
    flags.out_row   = r1 - lbp_pkg::ROW_W'(lbp_pkg::BORDER_PX);
    flags.out_col   = lbp_pkg::OUT_COL_W'(32'(c1) - 32'(lbp_pkg::BORDER_PX));
    col             = c1;

    col_next = last_col ? '0 : (c1 + CW'(1));
    if (last_col) begin
      row_next = last_row ? '0 : (r1 + lbp_pkg::ROW_W'(1));
    end else begin
      row_next = r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= WW'(lbp_pkg::clamp_u(32'(lbp_pkg::WIDTH_RESET), 32'(lbp_pkg::MIN_DIM),
                                    32'(MAX_WIDTH)));
      eff_h <= lbp_pkg::HEIGHT_W'(lbp_pkg::HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        lbp_pkg::REG_WIDTH: begin
          eff_w <= WW'(lbp_pkg::clamp_u(32'(cfg_data[lbp_pkg::WIDTH_CFG_W-1:0]),
                                        32'(lbp_pkg::MIN_DIM), 32'(MAX_WIDTH)));
        end
        lbp_pkg::REG_HEIGHT: begin
          eff_h <= lbp_pkg::HEIGHT_W'(lbp_pkg::clamp_u(32'(cfg_data),
                                                       32'(lbp_pkg::MIN_DIM),
                                                       32'(lbp_pkg::HEIGHT_MAX)));
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/lbp_window.sv]
// ----------------------------------------------------------------------------
// LBP window
// Keeps the two previous columns of the 3x3 neighborhood and forms the
// eight-bit pattern code against the center pixel.
// ----------------------------------------------------------------------------
module lbp_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  logic [lbp_pkg::PIX_W-1:0]   top,
  input  logic [lbp_pkg::PIX_W-1:0]   mid,
  input  logic [lbp_pkg::PIX_W-1:0]   bot,
  output logic [lbp_pkg::CODE_W-1:0]  code
);

  logic [lbp_pkg::PIX_W-1:0] win [6];
  logic [lbp_pkg::PIX_W-1:0] nb  [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (shift_en) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

  // Neighbors run clockwise from the top-left; the center is the middle of
  // the previous column.
  always_comb begin
    nb[0] = win[0];
    nb[1] = win[3];
    nb[2] = top;
    nb[3] = mid;
    nb[4] = bot;
    nb[5] = win[5];
    nb[6] = win[2];
    nb[7] = win[1];
    for (int k = 0; k < 8; k++) begin
      code[k] = nb[k] > win[4];
    end
  end

endmodule

[design/lbp_3x3_pixel_stream.sv]
// ----------------------------------------------------------------------------
// LBP 3x3 pixel stream
// Pixels enter in raster order on the pixel channel (pixel_valid and
// pixel_ready); one pattern code per interior pixel leaves on the code
// channel (code_valid and code_ready) with its output row and column and a
// frame_end mark on the last code of the frame. Border pixels give no code.
// The block takes one pixel per clock unless a waiting code is held by
// code_ready low. The edge that accepts a pixel also registers its line
// buffer read; when the read stage advances, the window compare is loaded
// into the output register and, for an interior pixel, code_valid is set.
// Image size is written on the cfg port (cfg_we, cfg_index, cfg_data) between
// frames; frame_start on a pixel restarts the position counters.
// Reset clears the counters, the window and the valid flags; the line
// buffer is not cleared and needs no clearing pass. When the receiver holds
// code_ready low, one more pixel is taken into the read stage and then
// pixel_ready drops until the waiting code is taken.
// ----------------------------------------------------------------------------
module lbp_3x3_pixel_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [lbp_pkg::PIX_W-1:0]        pixel,
  input  logic                             frame_start,
  output logic                             code_valid,
  input  logic                             code_ready,
  output logic [lbp_pkg::CODE_W-1:0]       code,
  output logic [lbp_pkg::ROW_W-1:0]        out_row,
  output logic [lbp_pkg::OUT_COL_W-1:0]    out_col,
  output logic                             frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                        accept;
  logic                        s1_adv;
  logic                        s1_valid;
  logic [lbp_pkg::PIX_W-1:0]   s1_pix;
  logic [CW-1:0]               s1_col;
  lbp_pkg::pos_flags_t         s1_flags;

  logic [CW-1:0]               col;
  lbp_pkg::pos_flags_t         flags;
  logic [lbp_pkg::LINE_W-1:0]  rd_line;
  logic [lbp_pkg::PIX_W-1:0]   top_px;
  logic [lbp_pkg::PIX_W-1:0]   mid_px;
  logic [lbp_pkg::CODE_W-1:0]  code_calc;
  logic                        code_valid_next;

  assign s1_adv      = s1_valid && (!code_valid || code_ready);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  assign top_px = rd_line[lbp_pkg::LINE_W-1:lbp_pkg::PIX_W];
  assign mid_px = rd_line[lbp_pkg::PIX_W-1:0];

  lbp_pos_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (accept),
    .frame_start(frame_start),
    .col        (col),
    .flags      (flags)
  );

  lbp_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(col),
    .wr_en  (s1_adv),
    .wr_addr(s1_col),
    .wr_data({mid_px, s1_pix}),
    .rd_data(rd_line)
  );

  lbp_window u_win (
    .clk     (clk),
    .rst     (rst),
    .shift_en(s1_adv),
    .top     (top_px),
    .mid     (mid_px),
    .bot     (s1_pix),
    .code    (code_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_col   <= col;
      s1_flags <= flags;
    end
  end

  always_comb begin
    if (s1_adv) begin
      code_valid_next = s1_flags.emit;
    end else if (code_ready) begin
      code_valid_next = 1'b0;
    end else begin
      code_valid_next = code_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else begin
      code_valid <= code_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.emit) begin
      code      <= code_calc;
      out_row   <= s1_flags.out_row;
      out_col   <= s1_flags.out_col;
      frame_end <= s1_flags.frame_end;
    end
  end

endmodule

[design/lbp_checker.sv]
// ----------------------------------------------------------------------------
// LBP checker
// Port-level checks of the 3x3 pattern block, attached to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  input  logic                             pixel_ready,
  input  logic                             code_valid,
  input  logic                             code_ready,
  input  logic [lbp_pkg::CODE_W-1:0]       code,
  input  logic [lbp_pkg::ROW_W-1:0]        out_row,
  input  logic [lbp_pkg::OUT_COL_W-1:0]    out_col,
  input  logic                             frame_end
);

  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code) && $stable(out_row) &&
                                  $stable(out_col) && $stable(frame_end))
    else $error("Stalled code request changed or dropped.");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !code_valid && pixel_ready)
    else $error("Block not empty after reset.");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> code_valid && !code_ready)
    else $error("Pixel request refused while the code side is free.");

  a_stall_one_more: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready && pixel_valid |=> pixel_valid)
    else $error("Pixel request withdrawn before acceptance.");

endmodule

bind lbp_3x3_pixel_stream lbp_checker u_lbp_checker (
  .clk        (clk),
  .rst        (rst),
  .pixel_valid(pixel_valid),
  .pixel_ready(pixel_ready),
  .code_valid (code_valid),
  .code_ready (code_ready),
  .code       (code),
  .out_row    (out_row),
  .out_col    (out_col),
  .frame_end  (frame_end)
);
